>>> hw/rtl/smp_pkg.sv
// types and constants shared by the sliding median peak cut detector
`default_nettype none
package smp_pkg;
   localparam int DIST_W  = 24;
   localparam int FRAME_W = 32;

   typedef struct packed {
      logic [FRAME_W-1:0] num;
      logic [FRAME_W-1:0] stamp;
   } frame_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT_WRITE,
      CELL_SHIFT,
      CELL_RANK,
      CELL_ROTATE
   } cell_op_type;

   localparam logic [1:0] ACT_FRAME  = 2'd0;
   localparam logic [1:0] ACT_FLUSH  = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   localparam logic [1:0] CSR_GAP_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_ENTER_FACTOR = 2'd1;
   localparam logic [1:0] CSR_EXIT_FACTOR  = 2'd2;
   localparam logic [1:0] CSR_MIN_DISTANCE = 2'd3;
endpackage
`default_nettype wire

>>> hw/rtl/smp_ifs.sv
// request and response channel interfaces
`default_nettype none
interface smp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] frame_number;
   logic [31:0] frame_time;
   logic [23:0] cut_distance;
   modport source(output valid, action, frame_number, frame_time, cut_distance, input ready);
   modport sink(input valid, action, frame_number, frame_time, cut_distance, output ready);
endinterface

interface smp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_frame;
   logic [31:0] end_frame;
   logic [31:0] mid_frame;
   logic [31:0] start_time;
   logic [31:0] end_time;
   logic [31:0] mid_time;
   logic [23:0] peak_distance;
   modport source(output valid, start_frame, end_frame, mid_frame, start_time, end_time,
                  mid_time, peak_distance, input ready);
   modport sink(input valid, start_frame, end_frame, mid_frame, start_time, end_time,
                mid_time, peak_distance, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/smp_cell.sv
// one window cell: distance, centre frame and rank counters
`default_nettype none
module smp_cell #(
   parameter int IDX   = 0,
   parameter int DEPTH = 72
) (
   input  logic                                clock,
   input  smp_pkg::cell_op_type                op,
   input  logic [$clog2(DEPTH+1)-1:0]          pos,
   input  logic [smp_pkg::DIST_W-1:0]          bcast,
   input  logic [smp_pkg::DIST_W-1:0]          new_dist,
   input  smp_pkg::frame_type                  new_frame,
   input  logic [smp_pkg::DIST_W-1:0]          right_dist,
   input  smp_pkg::frame_type                  right_frame,
   input  logic [$clog2(DEPTH+1)-1:0]          right_lt,
   input  logic [$clog2(DEPTH+1)-1:0]          right_le,
   input  logic [smp_pkg::DIST_W-1:0]          head_dist,
   input  smp_pkg::frame_type                  head_frame,
   input  logic [$clog2(DEPTH+1)-1:0]          head_lt,
   input  logic [$clog2(DEPTH+1)-1:0]          head_le,
   output logic [smp_pkg::DIST_W-1:0]          out_dist,
   output smp_pkg::frame_type                  out_frame,
   output logic [$clog2(DEPTH+1)-1:0]          out_lt,
   output logic [$clog2(DEPTH+1)-1:0]          out_le
);
   import smp_pkg::*;

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] MY   = CW'(IDX);
   localparam logic [CW-1:0] LAST = CW'(DEPTH-1);

   logic [DIST_W-1:0] dist_ff, dist_in;
   frame_type         frame_ff, frame_in;
   logic [CW-1:0]     lt_ff, lt_in, le_ff, le_in;
   logic              ranking;

   assign ranking   = (op == CELL_RANK);
   assign out_dist  = dist_ff;
   assign out_frame = frame_ff;
   assign out_lt    = lt_ff + CW'(ranking && (bcast < dist_ff));
   assign out_le    = le_ff + CW'(ranking && (bcast <= dist_ff));

   always_comb begin
      dist_in  = dist_ff;
      frame_in = frame_ff;
      lt_in    = lt_ff;
      le_in    = le_ff;
      case (op)
         CELL_WRITE: begin
            lt_in = '0;
            le_in = '0;
            if (MY == pos) begin
               dist_in  = new_dist;
               frame_in = new_frame;
            end
         end
         CELL_SHIFT_WRITE: begin
            lt_in = '0;
            le_in = '0;
            if (MY == LAST) begin
               dist_in  = new_dist;
               frame_in = new_frame;
            end else begin
               dist_in  = right_dist;
               frame_in = right_frame;
            end
         end
         CELL_SHIFT: begin
            lt_in = '0;
            le_in = '0;
            if (MY != LAST) begin
               dist_in  = right_dist;
               frame_in = right_frame;
            end
         end
         CELL_RANK, CELL_ROTATE: begin
            if (MY < pos) begin
               dist_in  = right_dist;
               frame_in = right_frame;
               lt_in    = right_lt;
               le_in    = right_le;
            end else if (MY == pos) begin
               dist_in  = head_dist;
               frame_in = head_frame;
               lt_in    = head_lt;
               le_in    = head_le;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dist_ff  <= dist_in;
      frame_ff <= frame_in;
      lt_ff    <= lt_in;
      le_ff    <= le_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/sliding_median_peak_cut_detector.sv
// Sliding median peak cut detector. One item is taken at a time. A new frame, or a flush that
// leaves entries in the window, passes the states apply, rank, scan and decide, and then send
// when it gives a result; a full window holds 72 entries. The window is a chain of cells that
// rotates once to rank every entry against every other, and once more to pick out the upper
// median and the centre entry at cell 0. A flush that leaves the window empty, and an unknown
// action, pass only apply; a finish passes apply and then send when it gives a result. A
// finished result waits in the response register while the next item is taken; a second
// result stalls until that register has been taken.
`default_nettype none
module sliding_median_peak_cut_detector #(
   parameter int FRAME_WINDOW   = 9,
   parameter int DISTANCE_DEPTH = 72
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data,
   smp_req_if.sink     req_chan,
   smp_rsp_if.source   rsp_chan
);
   import smp_pkg::*;

   localparam int CW = $clog2(DISTANCE_DEPTH+1);
   localparam int RW = $clog2(FRAME_WINDOW+1);
   localparam int RI = $clog2(FRAME_WINDOW);
   localparam logic [CW-1:0] DEPTH_C = CW'(DISTANCE_DEPTH);
   localparam logic [RW-1:0] FW_C    = RW'(FRAME_WINDOW);

   typedef enum logic [2:0] {S_IDLE, S_APPLY, S_RANK, S_SCAN, S_DECIDE, S_SEND} state_type;

   state_type         state_ff;
   logic [15:0]       gap_limit_ff;
   logic [3:0]        enter_factor_ff, exit_factor_ff;
   logic [DIST_W-1:0] min_distance_ff;

   logic [1:0]        item_act_ff;
   frame_type         item_frame_ff;
   logic [DIST_W-1:0] item_dist_ff;

   frame_type         ring_ff [FRAME_WINDOW];
   logic [RW-1:0]     rc_ff;
   logic [CW-1:0]     wc_ff, step_ff;
   logic              in_peak_ff, seen_ff, gap_ff;
   logic [DIST_W-1:0] peak_max_ff, centre_dist_ff, med_ff;
   frame_type         peak_frame_ff, seg_ff, last_ff, centre_frame_ff;
   frame_type         emit_a_ff, emit_b_ff;
   logic [DIST_W-1:0] emit_pk_ff;

   logic              rsp_valid_ff;
   frame_type         rsp_a_ff, rsp_b_ff;
   logic [31:0]       rsp_mid_num_ff, rsp_mid_stamp_ff;
   logic [DIST_W-1:0] rsp_pk_ff;

   // window chain
   cell_op_type       cop;
   logic [CW-1:0]     cpos;
   logic [DIST_W-1:0] c_dist [DISTANCE_DEPTH];
   frame_type         c_frame [DISTANCE_DEPTH];
   logic [CW-1:0]     c_lt [DISTANCE_DEPTH];
   logic [CW-1:0]     c_le [DISTANCE_DEPTH];
   logic [DIST_W-1:0] new_dist;
   frame_type         centre_new;

   // new frame bookkeeping
   logic              gap;
   logic [RW-1:0]     rc_eff, rc_new, mid_idx;
   logic              ring_full;
   logic [CW-1:0]     wc_eff, wc_new;
   logic              win_full;
   logic [31:0]       frame_diff;

   // peak decision
   logic [3:0]        ef;
   logic [27:0]       thr_in, thr_out, cd_w;
   logic              start_pk, ip1, upd, end_pk;
   logic [DIST_W-1:0] pm1, pm2;
   frame_type         pf1, pf2;
   logic [CW-1:0]     half;
   logic [32:0]       sum_num, sum_stamp;

   genvar gi;
   generate
      for (gi = 0; gi < DISTANCE_DEPTH; gi++) begin : g_cell
         localparam int NXT = (gi + 1) % DISTANCE_DEPTH;
         smp_cell #(.IDX(gi), .DEPTH(DISTANCE_DEPTH)) u_cell (
            .clock      (clock),
            .op         (cop),
            .pos        (cpos),
            .bcast      (c_dist[0]),
            .new_dist   (new_dist),
            .new_frame  (centre_new),
            .right_dist (c_dist[NXT]),
            .right_frame(c_frame[NXT]),
            .right_lt   (c_lt[NXT]),
            .right_le   (c_le[NXT]),
            .head_dist  (c_dist[0]),
            .head_frame (c_frame[0]),
            .head_lt    (c_lt[0]),
            .head_le    (c_le[0]),
            .out_dist   (c_dist[gi]),
            .out_frame  (c_frame[gi]),
            .out_lt     (c_lt[gi]),
            .out_le     (c_le[gi])
         );
      end
   endgenerate

   assign frame_diff = item_frame_ff.num - last_ff.num;
   assign gap = seen_ff && (item_frame_ff.num > last_ff.num) &&
                (frame_diff > {16'd0, gap_limit_ff});
   assign rc_eff    = gap ? '0 : rc_ff;
   assign ring_full = (rc_eff == FW_C);
   assign rc_new    = ring_full ? FW_C : rc_eff + RW'(1);
   assign mid_idx   = rc_new >> 1;
   assign wc_eff    = gap ? '0 : wc_ff;
   assign win_full  = (wc_eff == DEPTH_C);
   assign wc_new    = win_full ? DEPTH_C : wc_eff + CW'(1);
   assign new_dist  = (rc_new < RW'(2)) ? '0 : item_dist_ff;

   // ring entry at the middle after the push
   always_comb begin
      if (ring_full) begin
         if (mid_idx == FW_C - RW'(1)) centre_new = item_frame_ff;
         else centre_new = ring_ff[RI'(mid_idx + RW'(1))];
      end else begin
         if (mid_idx == rc_eff) centre_new = item_frame_ff;
         else centre_new = ring_ff[RI'(mid_idx)];
      end
   end

   always_comb begin
      cop  = CELL_HOLD;
      cpos = wc_ff - CW'(1);
      case (state_ff)
         S_APPLY: begin
            if (item_act_ff == ACT_FRAME) begin
               cop  = win_full ? CELL_SHIFT_WRITE : CELL_WRITE;
               cpos = wc_eff;
            end else if (item_act_ff == ACT_FLUSH && wc_ff != '0) begin
               cop = CELL_SHIFT;
            end
         end
         S_RANK:  cop = CELL_RANK;
         S_SCAN:  cop = CELL_ROTATE;
         default: cop = CELL_HOLD;
      endcase
   end

   assign half     = wc_ff >> 1;
   assign ef       = (enter_factor_ff == 4'd0) ? 4'd1 : enter_factor_ff;
   assign thr_in   = 28'(med_ff) * 28'(ef);
   assign thr_out  = 28'(med_ff) * 28'(exit_factor_ff);
   assign cd_w     = 28'(centre_dist_ff);
   assign start_pk = !in_peak_ff && (cd_w > thr_in) && (centre_dist_ff > min_distance_ff);
   assign ip1      = in_peak_ff || start_pk;
   assign pm1      = start_pk ? centre_dist_ff : peak_max_ff;
   assign pf1      = start_pk ? centre_frame_ff : peak_frame_ff;
   assign upd      = ip1 && (centre_dist_ff > pm1);
   assign pm2      = upd ? centre_dist_ff : pm1;
   assign pf2      = upd ? centre_frame_ff : pf1;
   assign end_pk   = ip1 && ((cd_w <= thr_out) || (centre_dist_ff < min_distance_ff));

   assign sum_num   = {1'b0, emit_a_ff.num} + {1'b0, emit_b_ff.num};
   assign sum_stamp = {1'b0, emit_a_ff.stamp} + {1'b0, emit_b_ff.stamp};

   assign req_chan.ready = (state_ff == S_IDLE);

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.start_frame   = rsp_a_ff.num;
   assign rsp_chan.end_frame     = rsp_b_ff.num;
   assign rsp_chan.mid_frame     = rsp_mid_num_ff;
   assign rsp_chan.start_time    = rsp_a_ff.stamp;
   assign rsp_chan.end_time      = rsp_b_ff.stamp;
   assign rsp_chan.mid_time      = rsp_mid_stamp_ff;
   assign rsp_chan.peak_distance = rsp_pk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff    <= 16'd10;
         enter_factor_ff <= 4'd2;
         exit_factor_ff  <= 4'd2;
         min_distance_ff <= 24'd65536;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GAP_LIMIT:    gap_limit_ff    <= csr_write_data[15:0];
            CSR_ENTER_FACTOR: enter_factor_ff <= csr_write_data[3:0];
            CSR_EXIT_FACTOR:  exit_factor_ff  <= csr_write_data[3:0];
            CSR_MIN_DISTANCE: min_distance_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_APPLY && item_act_ff == ACT_FRAME) begin
         if (ring_full) begin
            for (int i = 0; i < FRAME_WINDOW - 1; i++) ring_ff[i] <= ring_ff[i+1];
            ring_ff[FRAME_WINDOW-1] <= item_frame_ff;
         end else begin
            ring_ff[RI'(rc_eff)] <= item_frame_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rc_ff         <= '0;
         wc_ff         <= '0;
         step_ff       <= '0;
         in_peak_ff    <= 1'b0;
         seen_ff       <= 1'b0;
         gap_ff        <= 1'b0;
         peak_max_ff   <= '0;
         peak_frame_ff <= '0;
         seg_ff        <= '0;
         last_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_SEND) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  item_act_ff         <= req_chan.action;
                  item_frame_ff.num   <= req_chan.frame_number;
                  item_frame_ff.stamp <= req_chan.frame_time;
                  item_dist_ff        <= req_chan.cut_distance;
                  state_ff            <= S_APPLY;
               end
            end
            S_APPLY: begin
               step_ff <= '0;
               gap_ff  <= 1'b0;
               case (item_act_ff)
                  ACT_FRAME: begin
                     if (gap) begin
                        emit_a_ff     <= seg_ff;
                        emit_b_ff     <= last_ff;
                        emit_pk_ff    <= peak_max_ff;
                        peak_frame_ff <= last_ff;
                        seg_ff        <= item_frame_ff;
                        in_peak_ff    <= 1'b0;
                        peak_max_ff   <= '0;
                     end
                     gap_ff   <= gap;
                     last_ff  <= item_frame_ff;
                     seen_ff  <= 1'b1;
                     rc_ff    <= rc_new;
                     wc_ff    <= wc_new;
                     state_ff <= S_RANK;
                  end
                  ACT_FLUSH: begin
                     if (wc_ff != '0) wc_ff <= wc_ff - CW'(1);
                     state_ff <= (wc_ff > CW'(1)) ? S_RANK : S_IDLE;
                  end
                  ACT_FINISH: begin
                     if (seen_ff && seg_ff != last_ff) begin
                        emit_a_ff  <= seg_ff;
                        emit_b_ff  <= last_ff;
                        emit_pk_ff <= peak_max_ff;
                        state_ff   <= S_SEND;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_RANK: begin
               if (step_ff == wc_ff - CW'(1)) begin
                  step_ff  <= '0;
                  state_ff <= S_SCAN;
               end else begin
                  step_ff <= step_ff + CW'(1);
               end
            end
            S_SCAN: begin
               if (step_ff == half) begin
                  centre_dist_ff  <= c_dist[0];
                  centre_frame_ff <= c_frame[0];
               end
               if (c_lt[0] <= half && half < c_le[0]) med_ff <= c_dist[0];
               if (step_ff == wc_ff - CW'(1)) state_ff <= S_DECIDE;
               else step_ff <= step_ff + CW'(1);
            end
            S_DECIDE: begin
               in_peak_ff    <= ip1 && !end_pk;
               peak_max_ff   <= pm2;
               peak_frame_ff <= pf2;
               if (end_pk) seg_ff <= pf2;
               if (end_pk && !gap_ff) begin
                  emit_a_ff  <= seg_ff;
                  emit_b_ff  <= pf2;
                  emit_pk_ff <= pm2;
               end
               state_ff <= (end_pk || gap_ff) ? S_SEND : S_IDLE;
            end
            S_SEND: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_a_ff         <= emit_a_ff;
                  rsp_b_ff         <= emit_b_ff;
                  rsp_mid_num_ff   <= sum_num[32:1];
                  rsp_mid_stamp_ff <= sum_stamp[32:1];
                  rsp_pk_ff        <= emit_pk_ff;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> sim/sliding_median_peak_cut_detector_checker.sv
// checker that predicts detector segments from observed transfers and compares results
`default_nettype none
module sliding_median_peak_cut_detector_checker
   import smp_pkg::*;
#(
   parameter int FRAME_WINDOW   = 9,
   parameter int DISTANCE_DEPTH = 72
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data,
   smp_req_if          req_mon,
   smp_rsp_if          rsp_mon,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] start_frame, end_frame, mid_frame;
      logic [31:0] start_time, end_time, mid_time;
      logic [23:0] peak_distance;
   } segment_type;

   segment_type awaited_segments[$];

   logic [15:0] gap_limit;
   logic [3:0]  enter_factor, exit_factor;
   logic [23:0] min_distance;

   frame_type   recent_frames[FRAME_WINDOW];
   int          recent_count;
   logic [23:0] distances[DISTANCE_DEPTH];
   frame_type   centre_frames[DISTANCE_DEPTH];
   int          distance_count;
   bit          peaking;
   logic [23:0] peak_max;
   frame_type   peak_frame, segment_start, last_frame;
   bit          seen_any;

   function automatic segment_type make_segment(frame_type a, frame_type b);
      segment_type s;
      logic [32:0] sum;
      s.start_frame = a.num;
      s.end_frame   = b.num;
      sum = {1'b0, a.num} + {1'b0, b.num};
      s.mid_frame   = sum[32:1];
      s.start_time  = a.stamp;
      s.end_time    = b.stamp;
      sum = {1'b0, a.stamp} + {1'b0, b.stamp};
      s.mid_time    = sum[32:1];
      s.peak_distance = peak_max;
      return s;
   endfunction

   function automatic bit judge_peak(output segment_type s);
      logic [23:0] sorted[DISTANCE_DEPTH];
      logic [23:0] v;
      longint unsigned med, d, ef;
      frame_type centre;
      int j;
      s = '{default: '0};
      if (distance_count == 0) return 0;
      for (int i = 0; i < distance_count; i++) begin
         v = distances[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      med = sorted[distance_count/2];
      d = distances[distance_count/2];
      centre = centre_frames[distance_count/2];
      ef = (enter_factor != 0) ? enter_factor : 1;
      if (!peaking && d > med * ef && d > min_distance) begin
         peaking = 1;
         peak_max = d[23:0];
         peak_frame = centre;
      end
      if (peaking) begin
         if (d > peak_max) begin
            peak_max = d[23:0];
            peak_frame = centre;
         end
         if (d <= med * exit_factor || d < min_distance) begin
            peaking = 0;
            s = make_segment(segment_start, peak_frame);
            segment_start = peak_frame;
            return 1;
         end
      end
      return 0;
   endfunction

   task automatic take_item(logic [1:0] action, frame_type f, logic [23:0] distance);
      segment_type s, dropped;
      bit got;
      got = 0;
      case (action)
         ACT_FRAME: begin
            if (seen_any && f.num > last_frame.num && (f.num - last_frame.num) > gap_limit) begin
               peak_frame = last_frame;
               s = make_segment(segment_start, peak_frame);
               got = 1;
               segment_start = f;
               recent_count = 0;
               distance_count = 0;
               peaking = 0;
               peak_max = '0;
            end
            if (recent_count >= FRAME_WINDOW) begin
               for (int i = 1; i < FRAME_WINDOW; i++) recent_frames[i-1] = recent_frames[i];
               recent_count = FRAME_WINDOW - 1;
            end
            recent_frames[recent_count] = f;
            recent_count++;
            last_frame = f;
            seen_any = 1;
            if (recent_count < 2) distance = '0;
            if (distance_count >= DISTANCE_DEPTH) begin
               for (int i = 1; i < DISTANCE_DEPTH; i++) begin
                  distances[i-1] = distances[i];
                  centre_frames[i-1] = centre_frames[i];
               end
               distance_count = DISTANCE_DEPTH - 1;
            end
            distances[distance_count] = distance;
            centre_frames[distance_count] = recent_frames[recent_count/2];
            distance_count++;
            if (!got) got = judge_peak(s);
            else void'(judge_peak(dropped));
         end
         ACT_FLUSH: begin
            if (distance_count > 0) begin
               for (int i = 1; i < distance_count; i++) begin
                  distances[i-1] = distances[i];
                  centre_frames[i-1] = centre_frames[i];
               end
               distance_count--;
            end
            got = judge_peak(s);
         end
         ACT_FINISH: begin
            if (seen_any && segment_start != last_frame) begin
               s = make_segment(segment_start, last_frame);
               got = 1;
            end
         end
         default: ;
      endcase
      if (got) awaited_segments.push_back(s);
   endtask

   task automatic check_segment();
      segment_type e;
      if (awaited_segments.size() == 0) begin
         failures++;
         if (failures <= 10) $display("unexpected segment %0d..%0d", rsp_mon.start_frame,
                                      rsp_mon.end_frame);
         return;
      end
      e = awaited_segments.pop_front();
      if (rsp_mon.start_frame !== e.start_frame || rsp_mon.end_frame !== e.end_frame ||
          rsp_mon.mid_frame !== e.mid_frame || rsp_mon.start_time !== e.start_time ||
          rsp_mon.end_time !== e.end_time || rsp_mon.mid_time !== e.mid_time ||
          rsp_mon.peak_distance !== e.peak_distance) begin
         failures++;
         if (failures <= 10) begin
            $display("segment mismatch at %0t", $time);
            $display("  exp frames %h %h %h times %h %h %h peak %h", e.start_frame,
                     e.end_frame, e.mid_frame, e.start_time, e.end_time, e.mid_time,
                     e.peak_distance);
            $display("  got frames %h %h %h times %h %h %h peak %h", rsp_mon.start_frame,
                     rsp_mon.end_frame, rsp_mon.mid_frame, rsp_mon.start_time,
                     rsp_mon.end_time, rsp_mon.mid_time, rsp_mon.peak_distance);
         end
      end
   endtask

   initial begin
      failures = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      frame_type f;
      if (reset) begin
         gap_limit = 16'd10;
         enter_factor = 4'd2;
         exit_factor = 4'd2;
         min_distance = 24'd65536;
         recent_count = 0;
         distance_count = 0;
         peaking = 0;
         peak_max = '0;
         peak_frame = '0;
         segment_start = '0;
         last_frame = '0;
         seen_any = 0;
         awaited_segments.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GAP_LIMIT:    gap_limit = csr_write_data[15:0];
               CSR_ENTER_FACTOR: enter_factor = csr_write_data[3:0];
               CSR_EXIT_FACTOR:  exit_factor = csr_write_data[3:0];
               CSR_MIN_DISTANCE: min_distance = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) check_segment();
         if (req_mon.valid && req_mon.ready) begin
            f.num = req_mon.frame_number;
            f.stamp = req_mon.frame_time;
            take_item(req_mon.action, f, req_mon.cut_distance);
         end
      end
      pending = awaited_segments.size();
   end
endmodule
`default_nettype wire

>>> sim/sliding_median_peak_cut_detector_test.sv
// top of the detector testbench: clock, reset, stimulus and verdict
`default_nettype none
module sliding_median_peak_cut_detector_test;
   timeunit 1ns;
   timeprecision 1ps;
   import smp_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [23:0] csr_write_data;
   int          failures, pending;
   bit          quiet, hold_request;
   logic [31:0] cur_frame, cur_time;

   smp_req_if req_bus();
   smp_rsp_if rsp_bus();

   sliding_median_peak_cut_detector u_top (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_chan(req_bus.sink), .rsp_chan(rsp_bus.source)
   );

   sliding_median_peak_cut_detector_checker u_checker (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_mon(req_bus), .rsp_mon(rsp_bus), .failures(failures), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #20_000_000;
      $display("FAIL sliding_median_peak_cut_detector");
      $finish;
   end

   // receiver with random stalls and one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            hold_request = 0;
            repeat (800) @(negedge clock);
         end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [23:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send(logic [1:0] action, logic [31:0] num, logic [31:0] stamp,
                       logic [23:0] distance);
      req_bus.valid = 1'b1;
      req_bus.action = action;
      req_bus.frame_number = num;
      req_bus.frame_time = stamp;
      req_bus.cut_distance = distance;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic settle();
      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic send_frame(logic [23:0] distance);
      cur_frame += 32'd1;
      cur_time += 32'd40;
      send(ACT_FRAME, cur_frame, cur_time, distance);
   endtask

   task automatic random_items(int count);
      int r;
      logic [23:0] distance;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 85) distance = 24'($urandom_range(0, 40000));
         else distance = 24'($urandom_range(100000, 24'hFFFFFF));
         if (r < 80) begin
            r = $urandom_range(0, 99);
            if (r < 3) cur_frame += $urandom_range(1, 70000);
            else if (r < 5) cur_frame -= $urandom_range(1, 20);
            else if (r < 6) cur_frame = $urandom;
            else cur_frame += $urandom_range(1, 3);
            if ($urandom_range(0, 49) == 0) cur_time = $urandom;
            else cur_time += $urandom_range(30, 50);
            send(ACT_FRAME, cur_frame, cur_time, distance);
         end else if (r < 90) begin
            send(ACT_FLUSH, $urandom, $urandom, distance);
         end else if (r < 96) begin
            send(ACT_FINISH, $urandom, $urandom, distance);
         end else begin
            send(2'd3, $urandom, $urandom, distance);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      quiet = 0;
      hold_request = 0;
      csr_write_enable = 1'b0;
      csr_index = CSR_GAP_LIMIT;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_FRAME;
      req_bus.frame_number = '0;
      req_bus.frame_time = '0;
      req_bus.cut_distance = '0;
      cur_frame = '0;
      cur_time = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: empty finish and flush, single-frame ring, peaks, gaps, odd actions
      send(ACT_FINISH, '0, '0, '0);
      send(ACT_FLUSH, '0, '0, '0);
      send(ACT_FRAME, '0, '0, 24'hFFFFFF);
      for (int i = 0; i < 8; i++) send_frame(24'd1000);
      send_frame(24'hFFFFFF);
      send_frame(24'd200000);
      for (int i = 0; i < 5; i++) send_frame(24'd500);
      send(ACT_FLUSH, '0, '0, '0);
      send(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
      cur_frame += 32'd1000;
      send_frame(24'd100);
      send(ACT_FRAME, cur_frame - 32'd5, cur_time, 24'd300);
      send(ACT_FINISH, '0, '0, '0);
      send(ACT_FRAME, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
      settle();

      cur_frame = '0;
      write_csr(CSR_GAP_LIMIT, 24'd65535);
      write_csr(CSR_ENTER_FACTOR, 24'd1);
      write_csr(CSR_EXIT_FACTOR, 24'd1);
      write_csr(CSR_MIN_DISTANCE, 24'd0);
      random_items(130);
      settle();

      write_csr(CSR_GAP_LIMIT, 24'd1);
      write_csr(CSR_ENTER_FACTOR, 24'd15);
      write_csr(CSR_EXIT_FACTOR, 24'd15);
      write_csr(CSR_MIN_DISTANCE, 24'hFFFFFF);
      hold_request = 1;
      random_items(110);
      settle();

      write_csr(CSR_GAP_LIMIT, 24'd20);
      write_csr(CSR_ENTER_FACTOR, 24'd0);
      write_csr(CSR_EXIT_FACTOR, 24'd0);
      write_csr(CSR_MIN_DISTANCE, 24'd30000);
      random_items(130);
      settle();

      write_csr(CSR_GAP_LIMIT, 24'd10);
      write_csr(CSR_ENTER_FACTOR, 24'd3);
      write_csr(CSR_EXIT_FACTOR, 24'd2);
      write_csr(CSR_MIN_DISTANCE, 24'd65536);
      random_items(140);
      settle();

      quiet = 1;
      write_csr(CSR_ENTER_FACTOR, 24'd2);
      random_items(120);
      settle();

      if (failures == 0) begin
         $display("PASS sliding_median_peak_cut_detector");
      end else begin
         $display("FAIL sliding_median_peak_cut_detector");
      end
      $finish;
   end
endmodule
`default_nettype wire
